// File: design/bcc_pkg.sv
// Package for the button click classifier: shared types, codes and reset values.
// No dependencies; every other design file imports it.

package bcc_pkg;

    // Width of the free-running millisecond time base
    localparam int TIME_BITS = 32;

    // Widths of the fixed transaction fields and registers
    localparam int NOW_W   = 32;
    localparam int THR_W   = 16;
    localparam int EVENT_W = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [THR_W-1:0]     thr_t;

    // Button state machine
    typedef enum logic [1:0] {
        MODE_IDLE        = 2'd0,
        MODE_PRESSED     = 2'd1,
        MODE_RELEASED    = 2'd2,
        MODE_WAIT_DOUBLE = 2'd3
    } mode_t;

    // Reported key events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_SHORT  = 3'd1,
        EV_MEDIUM = 3'd2,
        EV_LONG   = 3'd3,
        EV_DOUBLE = 3'd4
    } key_event_t;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_LONG_PRESS   = 2'd0,
        REG_MEDIUM_PRESS = 2'd1,
        REG_DOUBLE_WIN   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam thr_t LONG_PRESS_RST   = 16'd2000;
    localparam thr_t MEDIUM_PRESS_RST = 16'd500;
    localparam thr_t DOUBLE_WIN_RST   = 16'd300;

    // Thresholds handed from the register block to the classifier
    typedef struct packed {
        thr_t long_press_ms;
        thr_t medium_press_ms;
        thr_t double_window_ms;
    } cfg_t;

endpackage

// File: design/bcc_in_if.sv
// Input channel of the button click classifier: one poll sample per transaction.
// Depends on bcc_pkg.

interface bcc_in_if
    import bcc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             key_pin;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output key_pin, output now_ms, input ready);
    modport sink   (input valid, input key_pin, input now_ms, output ready);
endinterface

// File: design/bcc_out_if.sv
// Output channel of the button click classifier: one key event per transaction.
// Depends on bcc_pkg.

interface bcc_out_if
    import bcc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

// File: design/bcc_cfg_regs.sv
// APB-style register block holding the three classifier thresholds.
// Depends on bcc_pkg.

module bcc_cfg_regs
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    thr_t     long_reg,   long_next;
    thr_t     medium_reg, medium_next;
    thr_t     window_reg, window_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    // Write decode; the unused slot ignores writes
    always_comb
    begin
        long_next   = long_reg;
        medium_next = medium_reg;
        window_next = window_reg;
        if (wr_en)
        begin
            case (idx)
                REG_LONG_PRESS:   long_next   = pwdata[THR_W-1:0];
                REG_MEDIUM_PRESS: medium_next = pwdata[THR_W-1:0];
                REG_DOUBLE_WIN:   window_next = pwdata[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg   <= LONG_PRESS_RST;
            medium_reg <= MEDIUM_PRESS_RST;
            window_reg <= DOUBLE_WIN_RST;
        end
        else
        begin
            long_reg   <= long_next;
            medium_reg <= medium_next;
            window_reg <= window_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_LONG_PRESS:   prdata = DATA_W'(long_reg);
            REG_MEDIUM_PRESS: prdata = DATA_W'(medium_reg);
            REG_DOUBLE_WIN:   prdata = DATA_W'(window_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.long_press_ms    = long_reg;
    assign cfg.medium_press_ms  = medium_reg;
    assign cfg.double_window_ms = window_reg;

endmodule

// File: design/bcc_classify.sv
// Button state machine with press and release time stamps; classifies one sample per step.
// Depends on bcc_pkg.

module bcc_classify
    import bcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             key_pin,
    input  logic [NOW_W-1:0] now_ms,
    input  cfg_t             cfg,
    output key_event_t       key_event
);

    mode_t mode_reg, mode_next;
    time_t press_reg, press_next;
    time_t release_reg, release_next;
    time_t now;
    time_t press_diff;
    time_t release_diff;
    time_t long_thr;
    time_t medium_thr;
    time_t window_thr;
    logic  pressed;
    logic  is_long;
    logic  is_medium;
    logic  in_window;
    logic  past_window;

    assign pressed = !key_pin;
    assign now     = time_t'(now_ms);

    // Wrapping time differences and threshold compares
    assign press_diff   = now - press_reg;
    assign release_diff = now - release_reg;
    assign long_thr     = time_t'(cfg.long_press_ms);
    assign medium_thr   = time_t'(cfg.medium_press_ms);
    assign window_thr   = time_t'(cfg.double_window_ms);
    assign is_long      = press_diff > long_thr;
    assign is_medium    = press_diff > medium_thr;
    assign in_window    = release_diff < window_thr;
    assign past_window  = release_diff > window_thr;

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE:
                if (pressed)
                    mode_next = MODE_PRESSED;
            MODE_PRESSED:
                if (!pressed)
                    mode_next = (is_long || is_medium) ? MODE_IDLE : MODE_RELEASED;
            MODE_RELEASED:
                if (pressed)
                    mode_next = in_window ? MODE_WAIT_DOUBLE : MODE_PRESSED;
                else if (past_window)
                    mode_next = MODE_IDLE;
            MODE_WAIT_DOUBLE:
                if (!pressed)
                    mode_next = MODE_IDLE;
            default:
                mode_next = MODE_IDLE;
        endcase
    end

    // Event and time stamps
    always_comb
    begin
        key_event    = EV_NONE;
        press_next   = press_reg;
        release_next = release_reg;
        case (mode_reg)
            MODE_IDLE:
                if (pressed)
                    press_next = now;
            MODE_PRESSED:
                if (!pressed)
                begin
                    release_next = now;
                    if (is_long)
                        key_event = EV_LONG;
                    else if (is_medium)
                        key_event = EV_MEDIUM;
                end
            MODE_RELEASED:
                if (pressed)
                begin
                    if (in_window)
                        key_event = EV_DOUBLE;
                    else
                    begin
                        key_event  = EV_SHORT;
                        press_next = now;
                    end
                end
                else if (past_window)
                    key_event = EV_SHORT;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            press_reg   <= '0;
            release_reg <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            press_reg   <= press_next;
            release_reg <= release_next;
        end
    end

endmodule

// File: design/button_click_classifier_top.sv
// Top level of the button click classifier: input register, classifier, result register.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_cfg_regs and bcc_classify.
//
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------
//  in_ch    | sink      | key_pin, now_ms (one poll sample)
//  out_ch   | source    | key_event (exactly one per sample)
//  APB      | slave     | threshold writes and reads, no wait states
//
// Throughput is one sample per clock while out_ch is not stalled; a sample passes the input
// register, then goes through the state machine into the result register.
// Reset (rst_n low, asynchronous) empties both registers, sets the state machine
// idle and loads the default thresholds.
// When out_ch is stalled the result register holds, the input register holds
// behind it, and in_ch.ready drops only when both are full.

module button_click_classifier_top
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bcc_in_if.sink            in_ch,
    bcc_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t             cfg;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_key_reg,   s1_key_next;
    logic [NOW_W-1:0] s1_now_reg,   s1_now_next;
    logic             out_valid_reg, out_valid_next;
    key_event_t       out_event_reg, out_event_next;
    key_event_t       key_event;
    logic             s1_adv;
    logic             step;

    bcc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline flow control
    assign s1_adv      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign step        = s1_valid_reg && s1_adv;

    bcc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .key_pin   (s1_key_reg),
        .now_ms    (s1_now_reg),
        .cfg       (cfg),
        .key_event (key_event)
    );

    // Input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_key_next   = s1_key_reg;
        s1_now_next   = s1_now_reg;
        if (in_ch.ready)
        begin
            s1_valid_next = in_ch.valid;
            s1_key_next   = in_ch.key_pin;
            s1_now_next   = in_ch.now_ms;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            out_event_next = key_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_key_reg    <= s1_key_next;
        s1_now_reg    <= s1_now_next;
        out_event_reg <= out_event_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.key_event = out_event_reg;

    // A sample leaving the input register always lands in the result register
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("sample lost between input and result register");

    // A held sample in the input register must not change under a stall
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_now_reg)
                                       && $stable(s1_key_reg)))
        else $error("input register changed while stalled");

    // Only defined event codes reach the output
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_event_reg == EV_NONE || out_event_reg == EV_SHORT
                           || out_event_reg == EV_MEDIUM || out_event_reg == EV_LONG
                           || out_event_reg == EV_DOUBLE))
        else $error("undefined key event code");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for button_click_classifier_top: poll samples and threshold settings go in,
// every key event is predicted on acceptance and checked in order. Depends on bcc_pkg,
// bcc_in_if, bcc_out_if and the classifier RTL.

module testbench
    import bcc_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 11;
    localparam int MAX_CYCLES   = 200000;
    localparam int DRAIN_CYCLES = 8;    // two-stage pipe plus margin
    localparam int CHOKE_AT     = 120;  // samples taken before the long output hold
    localparam int CHOKE_LEN    = 300;
    localparam int PHASE_POLLS  = 190;

    typedef struct packed {
        logic  key_pin;
        time_t now_ms;
    } poll_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bcc_in_if  in_ch ();
    bcc_out_if out_ch ();

    button_click_classifier_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Classifier state as predicted by the testbench
    thr_t  long_thr   = LONG_PRESS_RST;
    thr_t  medium_thr = MEDIUM_PRESS_RST;
    thr_t  window_thr = DOUBLE_WIN_RST;
    mode_t btn_mode   = MODE_IDLE;
    time_t press_at   = '0;
    time_t release_at = '0;

    poll_t       poll_q[$];
    key_event_t  event_q[$];
    int unsigned polls_made  = 0;
    int unsigned polls_taken = 0;
    int unsigned events_seen = 0;
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned in_gap      = 0;
    int unsigned out_wait    = 0;
    int unsigned choke_left  = 0;
    bit          choke_done  = 1'b0;
    bit          in_calm     = 1'b0;
    bit          out_calm    = 1'b0;
    time_t       t_cur       = '0;

    always #CLK_HALF clk = ~clk;

    // Known levels on every channel input before the first edge
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.key_pin = 1'b1;
        in_ch.now_ms  = '0;
        out_ch.ready  = 1'b0;
    end

    // Next key event for one poll sample; updates the predicted state
    function automatic key_event_t classify_sample(poll_t s);
        key_event_t ev      = EV_NONE;
        logic       pressed = !s.key_pin;
        time_t      since;
        case (btn_mode)
            MODE_IDLE:
            begin
                if (pressed)
                begin
                    btn_mode = MODE_PRESSED;
                    press_at = s.now_ms;
                end
            end
            MODE_PRESSED:
            begin
                if (!pressed)
                begin
                    since      = s.now_ms - press_at;
                    release_at = s.now_ms;
                    btn_mode   = MODE_RELEASED;
                    // long wins even when the thresholds are out of order
                    if (since > long_thr)
                    begin
                        ev       = EV_LONG;
                        btn_mode = MODE_IDLE;
                    end
                    else if (since > medium_thr)
                    begin
                        ev       = EV_MEDIUM;
                        btn_mode = MODE_IDLE;
                    end
                end
            end
            MODE_RELEASED:
            begin
                since = s.now_ms - release_at;
                if (pressed)
                begin
                    if (since < window_thr)
                    begin
                        ev       = EV_DOUBLE;
                        btn_mode = MODE_WAIT_DOUBLE;
                    end
                    else
                    begin
                        // slow second press: report the short one, time the new one
                        ev       = EV_SHORT;
                        btn_mode = MODE_PRESSED;
                        press_at = s.now_ms;
                    end
                end
                else if (since > window_thr)
                begin
                    ev       = EV_SHORT;
                    btn_mode = MODE_IDLE;
                end
            end
            default:
            begin
                if (!pressed)
                    btn_mode = MODE_IDLE;
            end
        endcase
        return ev;
    endfunction

    function automatic int unsigned draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Span clustered around a threshold, with wrap below zero
    function automatic time_t span_near(thr_t thr);
        case ($urandom_range(0, 5))
            0: return time_t'(thr) - 1;
            1: return time_t'(thr);
            2: return time_t'(thr) + 1;
            3: return $urandom_range(0, thr);
            4: return time_t'(thr) + $urandom_range(0, 200);
            default: return $urandom_range(0, 2 * thr + 10);
        endcase
    endfunction

    task automatic push_poll(logic lvl, time_t t);
        poll_q.push_back(poll_t'{lvl, t});
        polls_made++;
    endtask

    // One press and release, with polls around the double-click window before it
    task automatic add_click();
        time_t       hold;
        time_t       gap;
        int unsigned extra;
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) push_poll(1'b1, t_cur + span_near(window_thr));
        gap = span_near(window_thr);
        if ($urandom_range(0, 3) == 0)
            gap += $urandom_range(0, 4000);
        t_cur += gap;
        push_poll(1'b0, t_cur);
        case ($urandom_range(0, 3))
            0: hold = span_near(long_thr);
            1: hold = span_near(medium_thr);
            default: hold = $urandom_range(0, medium_thr);
        endcase
        repeat ($urandom_range(0, 2)) push_poll(1'b0, t_cur + $urandom_range(0, hold));
        t_cur += hold;
        push_poll(1'b1, t_cur);
    endtask

    // Random levels at random times, sometimes moving the time base
    task automatic add_noise();
        repeat ($urandom_range(1, 4)) push_poll(1'($urandom), $urandom);
        if ($urandom_range(0, 1) == 1)
            t_cur = $urandom;
    endtask

    task automatic run_phase(int unsigned n);
        int unsigned stop = polls_made + n;
        while (polls_made < stop)
        begin
            if ($urandom_range(0, 9) < 8)
                add_click();
            else
                add_noise();
        end
    endtask

    task automatic wait_idle();
        while (events_seen != polls_made)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; the register takes it at the access edge
    task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LONG_PRESS:   long_thr   = value[THR_W-1:0];
            REG_MEDIUM_PRESS: medium_thr = value[THR_W-1:0];
            REG_DOUBLE_WIN:   window_thr = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reg_check(reg_idx_t idx, thr_t want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[THR_W-1:0] !== want)
        begin
            $display("%0t: register %s expected %0d, got %0d",
                     $time, idx.name(), want, prdata[THR_W-1:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_thresholds();
        reg_check(REG_LONG_PRESS, long_thr);
        reg_check(REG_MEDIUM_PRESS, medium_thr);
        reg_check(REG_DOUBLE_WIN, window_thr);
    endtask

    // Upper data bits are junk; the unused index must change nothing
    task automatic set_thresholds(thr_t lng, thr_t med, thr_t win);
        reg_write(REG_LONG_PRESS, {16'($urandom), lng});
        reg_write(REG_MEDIUM_PRESS, {16'($urandom), med});
        reg_write(REG_DOUBLE_WIN, {16'($urandom), win});
        reg_write(REG_UNUSED, $urandom);
        check_thresholds();
    endtask

    // Poll sample driver
    always @(posedge clk)
    begin : poll_driver
        poll_t s;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end
            else if (poll_q.size() != 0)
            begin
                s = poll_q.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.key_pin <= s.key_pin;
                in_ch.now_ms  <= s.now_ms;
                in_gap        <= draw_gap(in_calm);
                if ($urandom_range(0, 31) == 0)
                    in_calm <= !in_calm;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Long output hold once, while samples keep coming
    always @(posedge clk)
    begin
        if (!rst_n)
            choke_left <= 0;
        else if (!choke_done && polls_taken >= CHOKE_AT)
        begin
            choke_left <= CHOKE_LEN;
            choke_done <= 1'b1;
        end
        else if (choke_left != 0)
            choke_left <= choke_left - 1;
    end

    // Event receiver with per-transaction stalls
    always @(posedge clk)
    begin : event_sink
        int unsigned hold;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_wait     <= 0;
        end
        else
        begin
            hold = out_wait;
            if (out_ch.valid && out_ch.ready)
            begin
                hold = draw_gap(out_calm);
                if ($urandom_range(0, 31) == 0)
                    out_calm <= !out_calm;
            end
            else if (hold != 0)
                hold--;
            out_wait     <= hold;
            out_ch.ready <= (hold == 0) && (choke_left == 0);
        end
    end

    // Predict on every accepted sample
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            event_q.push_back(classify_sample(poll_t'{in_ch.key_pin, in_ch.now_ms}));
            polls_taken <= polls_taken + 1;
        end
    end

    // Check every accepted event against the oldest prediction
    always @(posedge clk)
    begin : event_monitor
        key_event_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            events_seen++;
            if (event_q.size() == 0)
            begin
                $display("%0t: key_event expected none, got %0d", $time, out_ch.key_event);
                err_count++;
            end
            else
            begin
                want = event_q.pop_front();
                if (out_ch.key_event !== want)
                begin
                    $display("%0t: key_event expected %0d, got %0d",
                             $time, want, out_ch.key_event);
                    err_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        check_thresholds();

        // Directed part at the reset thresholds (2000 / 500 / 300)
        push_poll(1'b1, 32'd0);             // idle, key up
        push_poll(1'b0, 32'd1000);          // short press
        push_poll(1'b1, 32'd1300);
        push_poll(1'b1, 32'd1600);          // gap equal to window: stays released
        push_poll(1'b0, 32'd1600);          // press at the window edge: short, restart
        push_poll(1'b1, 32'd2100);          // duration equal to medium: still short
        push_poll(1'b0, 32'd2399);          // inside window: double click
        push_poll(1'b0, 32'd2500);
        push_poll(1'b1, 32'd2600);          // release after double: back to idle
        push_poll(1'b0, 32'd3000);
        push_poll(1'b1, 32'd5001);          // just over long
        push_poll(1'b0, 32'd6000);
        push_poll(1'b1, 32'd8000);          // equal to long: medium
        push_poll(1'b0, 32'd10000);
        push_poll(1'b1, 32'd10100);
        push_poll(1'b1, 32'd10401);         // timeout: short
        push_poll(1'b0, 32'hFFFF_FF00);
        push_poll(1'b1, 32'h0000_0100);     // across the wrap: medium
        push_poll(1'b0, 32'd5000);
        push_poll(1'b1, 32'd4000);          // time going backwards: long
        push_poll(1'b0, 32'hFFFF_FFFF);
        push_poll(1'b1, 32'hFFFF_FFFF);     // zero duration
        push_poll(1'b1, 32'h0000_0000);
        push_poll(1'b1, 32'h0000_012C);     // timeout across the wrap: short
        wait_idle();

        // Random phases over several threshold settings
        t_cur = 32'd20000;
        run_phase(PHASE_POLLS);
        wait_idle();
        set_thresholds(16'd3000, 16'd800, 16'd400);
        run_phase(PHASE_POLLS);
        wait_idle();
        set_thresholds(16'd0, 16'd0, 16'd0);
        run_phase(PHASE_POLLS);
        wait_idle();
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        t_cur = 32'hFFFF_8000;
        run_phase(PHASE_POLLS);
        wait_idle();
        set_thresholds(16'd100, 16'd900, 16'd50);   // medium above long
        run_phase(PHASE_POLLS);
        wait_idle();
        set_thresholds(16'd40, 16'd12, 16'd8);
        run_phase(PHASE_POLLS);
        wait_idle();
        set_thresholds(thr_t'($urandom_range(0, 4000)), thr_t'($urandom_range(0, 1500)),
                       thr_t'($urandom_range(0, 600)));
        run_phase(PHASE_POLLS);
        wait_idle();

        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
